// ===== rtl/rrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsp_pkg: shared types and constants for the reply stream parser
// Byte classes, parser states, result kinds, queue entry and helpers.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  // Counter and position widths
  localparam int COUNT_BITS    = 32;
  localparam int POSITION_BITS = 32;
  localparam int OUT_BITS      = 32;
  localparam int COUNT_EXT     = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam int POS_EXT       = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;
  localparam int ACC_BITS      = COUNT_BITS + 4;

  // Token queue between front and back (power of two depth)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Characters of the reply syntax
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_PLUS   = 8'h2B;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [3:0] DIGIT_ONE  = 4'd1;

  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OUT_BITS-1:0]      word_t;

  typedef enum logic [3:0] {
    CLS_DIGIT,
    CLS_CR,
    CLS_LF,
    CLS_DOLLAR,
    CLS_PLUS,
    CLS_MINUS,
    CLS_STAR,
    CLS_COLON,
    CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    KIND_STATUS     = 3'd0,
    KIND_ERROR      = 3'd1,
    KIND_INTEGER    = 3'd2,
    KIND_BULK       = 3'd3,
    KIND_NIL_BULK   = 3'd4,
    KIND_MB_HEADER  = 3'd5,
    KIND_NIL_MB     = 3'd6,
    KIND_STREAM_ERR = 3'd7
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE        = 5'd0,
    ST_STATUS      = 5'd1,
    ST_STATUS_LF   = 5'd2,
    ST_ERROR       = 5'd3,
    ST_ERROR_LF    = 5'd4,
    ST_BULK_HDR    = 5'd5,
    ST_BULK_NIL    = 5'd6,
    ST_BULK_NIL_CR = 5'd7,
    ST_BULK_NIL_LF = 5'd8,
    ST_BULK_LEN    = 5'd9,
    ST_BULK_LEN_LF = 5'd10,
    ST_BULK_DATA   = 5'd11,
    ST_BULK_END_LF = 5'd12,
    ST_MB_HDR      = 5'd13,
    ST_MB_NIL      = 5'd14,
    ST_MB_NIL_CR   = 5'd15,
    ST_MB_NIL_LF   = 5'd16,
    ST_MB_CNT      = 5'd17,
    ST_MB_CNT_LF   = 5'd18,
    ST_INTEGER     = 5'd19,
    ST_INTEGER_LF  = 5'd20,
    ST_DEAD        = 5'd21
  } parse_state_t;

  // Decimal accumulate: v*10+d, saturating at all ones
  function automatic count_t acc_digit(count_t v, logic [3:0] d);
    logic [ACC_BITS-1:0] sum;
    sum = (ACC_BITS'(v) << 3) + (ACC_BITS'(v) << 1) + ACC_BITS'(d);
    if (sum[ACC_BITS-1:COUNT_BITS] != '0) begin
      return '1;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  // Low output bits of a stream position
  function automatic word_t pos_to_word(pos_t p);
    logic [POS_EXT-1:0] ext;
    ext = POS_EXT'(p);
    return ext[OUT_BITS-1:0];
  endfunction

  // Element count limited to the output width
  function automatic word_t count_to_word(count_t c);
    logic [COUNT_EXT-1:0] ext;
    ext = COUNT_EXT'(c);
    if (ext > COUNT_EXT'({OUT_BITS{1'b1}})) begin
      return '1;
    end
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/resp_reply_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_unit: byte-serial reply stream parser
// Input channel (in_*): one stream byte per transfer on in_data_byte.
// Result channel (out_*): one registered result per completed reply element:
//   kind, payload offset, payload length (or element count), child flags.
// A malformed byte yields one stream-error result; later bytes are taken
//   and dropped silently until reset.
// Throughput: one byte per cycle while out_stall is low. A byte goes through the
//   classifier into a 4-entry token queue, and the parse engine consumes one
//   token per cycle whenever its result register is empty or being taken.
// The byte that completes a result is written into the queue, then the
//   engine steps it into the result register.
// Stall: out_stall holds the result register; the engine stops, the queue
//   fills and in_stall rises once it holds 4 tokens.
// Reset (rst_n low, synchronous): parser idle, position and counters zero,
//   queue and result channel empty.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_reply_kind,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_length,
  output logic        out_is_child,
  output logic        out_last_child
);

  rrsp_pkg::q_status_t q_status;
  rrsp_pkg::token_t    push_token;
  rrsp_pkg::token_t    pop_token;
  logic                push;
  logic                pop;

  // Classifier
  rrsp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_status     (q_status),
    .push         (push),
    .push_token   (push_token)
  );

  // Token queue
  rrsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .pop_token  (pop_token),
    .q_status   (q_status)
  );

  // Parse engine
  rrsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .pop_token       (pop_token),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reply_kind  (out_reply_kind),
    .out_data_offset (out_data_offset),
    .out_data_length (out_data_length),
    .out_is_child    (out_is_child),
    .out_last_child  (out_last_child)
  );

endmodule

// ===== rtl/rrsp_front.sv =====
// ----------------------------------------------------------------------------
// rrsp_front: input side of the reply stream parser
// Takes raw bytes, classifies them into tokens and pushes them to the queue.
// ----------------------------------------------------------------------------
module rrsp_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  rrsp_pkg::q_status_t q_status,
  output logic               push,
  output rrsp_pkg::token_t   push_token
);

  logic [7:0] digit_off;

  // Hold off the sender while the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Byte classification
  assign digit_off = in_data_byte - rrsp_pkg::CHR_ZERO;

  always_comb begin
    push_token.digit = digit_off[3:0];
    if (in_data_byte >= rrsp_pkg::CHR_ZERO && in_data_byte <= rrsp_pkg::CHR_NINE) begin
      push_token.cls = rrsp_pkg::CLS_DIGIT;
    end else begin
      case (in_data_byte)
        rrsp_pkg::CHR_CR:     push_token.cls = rrsp_pkg::CLS_CR;
        rrsp_pkg::CHR_LF:     push_token.cls = rrsp_pkg::CLS_LF;
        rrsp_pkg::CHR_DOLLAR: push_token.cls = rrsp_pkg::CLS_DOLLAR;
        rrsp_pkg::CHR_PLUS:   push_token.cls = rrsp_pkg::CLS_PLUS;
        rrsp_pkg::CHR_MINUS:  push_token.cls = rrsp_pkg::CLS_MINUS;
        rrsp_pkg::CHR_STAR:   push_token.cls = rrsp_pkg::CLS_STAR;
        rrsp_pkg::CHR_COLON:  push_token.cls = rrsp_pkg::CLS_COLON;
        default:              push_token.cls = rrsp_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

// ===== rtl/rrsp_queue.sv =====
// ----------------------------------------------------------------------------
// rrsp_queue: token queue between front and back
// Small flop-based FIFO; lets the front keep taking bytes while the back stalls.
// ----------------------------------------------------------------------------
module rrsp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rrsp_pkg::token_t    push_token,
  input  logic                pop,
  output rrsp_pkg::token_t    pop_token,
  output rrsp_pkg::q_status_t q_status
);

  rrsp_pkg::token_t               entry_r [rrsp_pkg::QUEUE_DEPTH];
  logic [rrsp_pkg::QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrsp_pkg::QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrsp_pkg::QPTR_BITS:0]   cnt_r, cnt_nxt;

  // Status and head entry
  assign q_status.full  = (cnt_r == (rrsp_pkg::QPTR_BITS + 1)'(rrsp_pkg::QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign pop_token      = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

// ===== rtl/rrsp_back.sv =====
// ----------------------------------------------------------------------------
// rrsp_back: parse engine of the reply stream parser
// Walks the reply state machine one token per cycle while its result slot is free,
// keeps position and counters, and drives the registered result channel.
// ----------------------------------------------------------------------------
module rrsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rrsp_pkg::q_status_t q_status,
  input  rrsp_pkg::token_t    pop_token,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_reply_kind,
  output logic [31:0]         out_data_offset,
  output logic [31:0]         out_data_length,
  output logic                out_is_child,
  output logic                out_last_child
);

  rrsp_pkg::parse_state_t state_r, state_nxt;
  rrsp_pkg::pos_t         pos_r, pos_nxt;
  rrsp_pkg::pos_t         mark_r, mark_nxt;
  rrsp_pkg::count_t       bulk_r, bulk_nxt;
  rrsp_pkg::count_t       elem_r, elem_nxt;

  logic                   out_valid_r, out_valid_nxt;
  rrsp_pkg::kind_t        out_kind_r, res_kind;
  rrsp_pkg::word_t        out_offset_r, res_offset;
  rrsp_pkg::word_t        out_length_r, res_length;
  logic                   out_child_r, res_child;
  logic                   out_last_r, res_last;

  logic                   take;
  logic                   bad;
  logic                   emit;
  logic                   is_dig;
  logic                   is_one;
  rrsp_pkg::byte_class_t  cls;
  rrsp_pkg::pos_t         pos_inc;
  rrsp_pkg::pos_t         line_len;

  // Token is consumed when the result slot is free or draining
  assign take   = !q_status.empty && (!out_valid_r || !out_stall);
  assign pop    = take;
  assign cls    = pop_token.cls;
  assign is_dig = (cls == rrsp_pkg::CLS_DIGIT);
  assign is_one = is_dig && (pop_token.digit == rrsp_pkg::DIGIT_ONE);

  assign pos_inc  = pos_r + 1'b1;
  assign line_len = pos_r - mark_r - 1'b1;

  // Next state and malformed-byte detection
  always_comb begin
    state_nxt = state_r;
    bad       = 1'b0;
    if (take) begin
      case (state_r)
        rrsp_pkg::ST_IDLE: begin
          if (cls == rrsp_pkg::CLS_DOLLAR) begin
            state_nxt = rrsp_pkg::ST_BULK_HDR;
          end else if (elem_r != '0) begin
            bad = 1'b1;
          end else begin
            case (cls)
              rrsp_pkg::CLS_PLUS:  state_nxt = rrsp_pkg::ST_STATUS;
              rrsp_pkg::CLS_MINUS: state_nxt = rrsp_pkg::ST_ERROR;
              rrsp_pkg::CLS_STAR:  state_nxt = rrsp_pkg::ST_MB_HDR;
              rrsp_pkg::CLS_COLON: state_nxt = rrsp_pkg::ST_INTEGER;
              default:             bad = 1'b1;
            endcase
          end
        end
        rrsp_pkg::ST_STATUS: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_STATUS_LF;
        end
        rrsp_pkg::ST_ERROR: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_ERROR_LF;
        end
        rrsp_pkg::ST_INTEGER: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_INTEGER_LF;
        end
        rrsp_pkg::ST_STATUS_LF, rrsp_pkg::ST_ERROR_LF, rrsp_pkg::ST_INTEGER_LF,
        rrsp_pkg::ST_BULK_NIL_LF, rrsp_pkg::ST_BULK_END_LF, rrsp_pkg::ST_MB_NIL_LF,
        rrsp_pkg::ST_MB_CNT_LF: begin
          if (cls == rrsp_pkg::CLS_LF) state_nxt = rrsp_pkg::ST_IDLE;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_HDR: begin
          if (cls == rrsp_pkg::CLS_MINUS) state_nxt = rrsp_pkg::ST_BULK_NIL;
          else if (is_dig) state_nxt = rrsp_pkg::ST_BULK_LEN;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_NIL: begin
          if (is_one) state_nxt = rrsp_pkg::ST_BULK_NIL_CR;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_MB_NIL: begin
          if (is_one) state_nxt = rrsp_pkg::ST_MB_NIL_CR;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_NIL_CR: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_BULK_NIL_LF;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_MB_NIL_CR: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_MB_NIL_LF;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_LEN: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_BULK_LEN_LF;
          else if (!is_dig) bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_LEN_LF: begin
          if (cls == rrsp_pkg::CLS_LF) state_nxt = rrsp_pkg::ST_BULK_DATA;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_BULK_DATA: begin
          if (bulk_r == '0) begin
            if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_BULK_END_LF;
            else bad = 1'b1;
          end
        end
        rrsp_pkg::ST_MB_HDR: begin
          if (cls == rrsp_pkg::CLS_MINUS) state_nxt = rrsp_pkg::ST_MB_NIL;
          else if (is_dig) state_nxt = rrsp_pkg::ST_MB_CNT;
          else bad = 1'b1;
        end
        rrsp_pkg::ST_MB_CNT: begin
          if (cls == rrsp_pkg::CLS_CR) state_nxt = rrsp_pkg::ST_MB_CNT_LF;
          else if (!is_dig) bad = 1'b1;
        end
        rrsp_pkg::ST_DEAD: state_nxt = rrsp_pkg::ST_DEAD;
        default: state_nxt = rrsp_pkg::ST_DEAD;
      endcase
      if (bad) state_nxt = rrsp_pkg::ST_DEAD;
    end
  end

  // Counters, position and result generation
  always_comb begin
    pos_nxt    = pos_r;
    mark_nxt   = mark_r;
    bulk_nxt   = bulk_r;
    elem_nxt   = elem_r;
    emit       = 1'b0;
    res_kind   = rrsp_pkg::KIND_STREAM_ERR;
    res_offset = rrsp_pkg::pos_to_word(pos_r);
    res_length = '0;
    res_child  = 1'b0;
    res_last   = 1'b0;
    if (take && bad) begin
      // stream error: position stays on the offending byte
      emit = 1'b1;
    end else if (take && state_r != rrsp_pkg::ST_DEAD) begin
      pos_nxt = pos_inc;
      case (state_r)
        rrsp_pkg::ST_IDLE: begin
          if (cls == rrsp_pkg::CLS_PLUS || cls == rrsp_pkg::CLS_MINUS ||
              cls == rrsp_pkg::CLS_COLON) begin
            mark_nxt = pos_inc;
          end
        end
        rrsp_pkg::ST_STATUS_LF, rrsp_pkg::ST_ERROR_LF, rrsp_pkg::ST_INTEGER_LF: begin
          emit       = 1'b1;
          res_kind   = (state_r == rrsp_pkg::ST_STATUS_LF) ? rrsp_pkg::KIND_STATUS :
                       (state_r == rrsp_pkg::ST_ERROR_LF)  ? rrsp_pkg::KIND_ERROR :
                                                             rrsp_pkg::KIND_INTEGER;
          res_offset = rrsp_pkg::pos_to_word(mark_r);
          res_length = rrsp_pkg::pos_to_word(line_len);
        end
        rrsp_pkg::ST_BULK_HDR: begin
          if (is_dig) bulk_nxt = rrsp_pkg::COUNT_BITS'(pop_token.digit);
        end
        rrsp_pkg::ST_BULK_LEN: begin
          if (is_dig) bulk_nxt = rrsp_pkg::acc_digit(bulk_r, pop_token.digit);
        end
        rrsp_pkg::ST_BULK_LEN_LF: mark_nxt = pos_inc;
        rrsp_pkg::ST_BULK_DATA: begin
          if (bulk_r != '0) bulk_nxt = bulk_r - 1'b1;
        end
        rrsp_pkg::ST_BULK_NIL_LF, rrsp_pkg::ST_BULK_END_LF: begin
          // element done; flagged as a child while a multibulk is open
          emit = 1'b1;
          if (state_r == rrsp_pkg::ST_BULK_NIL_LF) begin
            res_kind   = rrsp_pkg::KIND_NIL_BULK;
            res_offset = '0;
          end else begin
            res_kind   = rrsp_pkg::KIND_BULK;
            res_offset = rrsp_pkg::pos_to_word(mark_r);
            res_length = rrsp_pkg::pos_to_word(line_len);
          end
          if (elem_r != '0) begin
            elem_nxt  = elem_r - 1'b1;
            res_child = 1'b1;
            res_last  = (elem_r == rrsp_pkg::COUNT_BITS'(1));
          end
        end
        rrsp_pkg::ST_MB_HDR: begin
          if (is_dig) elem_nxt = rrsp_pkg::COUNT_BITS'(pop_token.digit);
        end
        rrsp_pkg::ST_MB_CNT: begin
          if (is_dig) elem_nxt = rrsp_pkg::acc_digit(elem_r, pop_token.digit);
        end
        rrsp_pkg::ST_MB_NIL_LF: begin
          emit       = 1'b1;
          res_kind   = rrsp_pkg::KIND_NIL_MB;
          res_offset = '0;
        end
        rrsp_pkg::ST_MB_CNT_LF: begin
          emit       = 1'b1;
          res_kind   = rrsp_pkg::KIND_MB_HEADER;
          res_offset = '0;
          res_length = rrsp_pkg::count_to_word(elem_r);
        end
        default: ;
      endcase
    end
  end

  // Result slot: holds while stalled, refilled as it drains
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrsp_pkg::ST_IDLE;
      pos_r       <= '0;
      mark_r      <= '0;
      bulk_r      <= '0;
      elem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      mark_r      <= mark_nxt;
      bulk_r      <= bulk_nxt;
      elem_r      <= elem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= res_kind;
      out_offset_r <= res_offset;
      out_length_r <= res_length;
      out_child_r  <= res_child;
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_data_offset = out_offset_r;
  assign out_data_length = out_length_r;
  assign out_is_child    = out_child_r;
  assign out_last_child  = out_last_r;

endmodule

// ===== rtl/resp_reply_stream_parser_unit_chk.sv =====
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_unit_chk: port-level checks for the parser
// Watches the result channel for consistency of kinds and flags.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser_unit_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_reply_kind,
  input logic [31:0] out_data_offset,
  input logic [31:0] out_data_length,
  input logic        out_is_child,
  input logic        out_last_child
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_kind) &&
    $stable(out_data_offset) && $stable(out_data_length) &&
    $stable(out_is_child) && $stable(out_last_child))
    else $error("result changed while stalled");

  // Last-child only on bulk-type children
  a_last_is_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_child |-> out_is_child &&
    (out_reply_kind == rrsp_pkg::KIND_BULK || out_reply_kind == rrsp_pkg::KIND_NIL_BULK))
    else $error("last child flag on a non-child result");

  // Nil kinds and headers carry no offset
  a_nil_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_kind == rrsp_pkg::KIND_NIL_BULK ||
    out_reply_kind == rrsp_pkg::KIND_NIL_MB || out_reply_kind == rrsp_pkg::KIND_MB_HEADER)
    |-> out_data_offset == '0)
    else $error("nonzero offset on nil or header result");

  // Stream error carries no length and no child flags
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind == rrsp_pkg::KIND_STREAM_ERR |->
    out_data_length == '0 && !out_is_child && !out_last_child)
    else $error("stream error result with stray fields");

endmodule

bind resp_reply_stream_parser_unit resp_reply_stream_parser_unit_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_reply_kind  (out_reply_kind),
  .out_data_offset (out_data_offset),
  .out_data_length (out_data_length),
  .out_is_child    (out_is_child),
  .out_last_child  (out_last_child)
);

// ===== bench/resp_reply_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// resp_reply_checker: result predictor and comparator for the parser
// Watches both channels of the reply stream parser. Every accepted input
// byte steps a local copy of the parse machine, which queues the result the
// byte completes. Every accepted result is checked field by field against
// the oldest queued one. Reports the failure tally and the count of results
// still awaited.
// ----------------------------------------------------------------------------
module resp_reply_checker
  import rrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_reply_kind,
  input  logic [31:0] out_data_offset,
  input  logic [31:0] out_data_length,
  input  logic        out_is_child,
  input  logic        out_last_child,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [7:0] CHR_ONE    = CHR_ZERO + 8'd1;

  typedef struct {
    kind_t kind;
    word_t offset;
    word_t length;
    logic  child;
    logic  last;
  } reply_t;

  reply_t       awaited_replies[$];
  parse_state_t parser_state;
  pos_t         stream_pos;
  pos_t         payload_start;
  count_t       bulk_left;
  count_t       elems_left;
  int           fail_tally = 0;

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= CHR_ZERO && ch <= CHR_NINE;
  endfunction

  // Decimal count step, saturating at all ones
  function automatic count_t add_digit(count_t v, logic [7:0] ch);
    logic [COUNT_BITS+3:0] wide;
    wide = (COUNT_BITS+4)'(v) * 10 + (COUNT_BITS+4)'(ch - CHR_ZERO);
    if (wide[COUNT_BITS+3:COUNT_BITS] != '0) begin
      return '1;
    end
    return wide[COUNT_BITS-1:0];
  endfunction

  // Payload bytes before CR, seen from the LF byte
  function automatic word_t line_length();
    pos_t span;
    span = stream_pos - payload_start - 1'b1;
    return word_t'(span);
  endfunction

  task automatic await_reply(kind_t k, word_t off, word_t len, logic child, logic last);
    reply_t r;
    r.kind   = k;
    r.offset = off;
    r.length = len;
    r.child  = child;
    r.last   = last;
    awaited_replies.push_back(r);
  endtask

  // Bulk or nil bulk: a child while a multibulk count is running
  task automatic await_element(kind_t k, word_t off, word_t len);
    if (elems_left != '0) begin
      elems_left = elems_left - 1'b1;
      await_reply(k, off, len, 1'b1, elems_left == '0);
    end else begin
      await_reply(k, off, len, 1'b0, 1'b0);
    end
  endtask

  // One byte through the parse machine
  task automatic advance_parser(input logic [7:0] ch);
    parse_state_t nxt;
    pos_t         nxt_pos;
    logic         bad;
    kind_t        line_kind;
    word_t        count_word;
    nxt     = parser_state;
    nxt_pos = stream_pos + 1'b1;
    bad     = 1'b0;
    if (parser_state == ST_DEAD) begin
      return;
    end
    case (parser_state)
      ST_IDLE: begin
        if (ch == CHR_DOLLAR) begin
          nxt = ST_BULK_HDR;
        end else if (elems_left != '0) begin
          bad = 1'b1;
        end else if (ch == CHR_PLUS) begin
          nxt = ST_STATUS;
          payload_start = nxt_pos;
        end else if (ch == CHR_MINUS) begin
          nxt = ST_ERROR;
          payload_start = nxt_pos;
        end else if (ch == CHR_STAR) begin
          nxt = ST_MB_HDR;
        end else if (ch == CHR_COLON) begin
          nxt = ST_INTEGER;
          payload_start = nxt_pos;
        end else begin
          bad = 1'b1;
        end
      end
      // line bodies: anything but CR is payload
      ST_STATUS, ST_ERROR, ST_INTEGER: begin
        if (ch == CHR_CR) nxt = parse_state_t'(parser_state + 5'd1);
      end
      ST_STATUS_LF, ST_ERROR_LF, ST_INTEGER_LF: begin
        if (ch == CHR_LF) begin
          line_kind = (parser_state == ST_STATUS_LF) ? KIND_STATUS :
                      (parser_state == ST_ERROR_LF)  ? KIND_ERROR  : KIND_INTEGER;
          await_reply(line_kind, word_t'(payload_start), line_length(), 1'b0, 1'b0);
          nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_BULK_HDR: begin
        if (ch == CHR_MINUS) begin
          nxt = ST_BULK_NIL;
        end else if (is_digit(ch)) begin
          bulk_left = count_t'(ch - CHR_ZERO);
          nxt = ST_BULK_LEN;
        end else begin
          bad = 1'b1;
        end
      end
      ST_BULK_NIL, ST_MB_NIL: begin
        if (ch == CHR_ONE) nxt = parse_state_t'(parser_state + 5'd1);
        else bad = 1'b1;
      end
      ST_BULK_NIL_CR, ST_MB_NIL_CR: begin
        if (ch == CHR_CR) nxt = parse_state_t'(parser_state + 5'd1);
        else bad = 1'b1;
      end
      ST_BULK_NIL_LF: begin
        if (ch == CHR_LF) begin
          await_element(KIND_NIL_BULK, '0, '0);
          nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_BULK_LEN: begin
        if (ch == CHR_CR) nxt = ST_BULK_LEN_LF;
        else if (is_digit(ch)) bulk_left = add_digit(bulk_left, ch);
        else bad = 1'b1;
      end
      ST_BULK_LEN_LF: begin
        if (ch == CHR_LF) begin
          nxt = ST_BULK_DATA;
          payload_start = nxt_pos;
        end else begin
          bad = 1'b1;
        end
      end
      // payload bytes are skipped whatever their value
      ST_BULK_DATA: begin
        if (bulk_left != '0) bulk_left = bulk_left - 1'b1;
        else if (ch == CHR_CR) nxt = ST_BULK_END_LF;
        else bad = 1'b1;
      end
      ST_BULK_END_LF: begin
        if (ch == CHR_LF) begin
          await_element(KIND_BULK, word_t'(payload_start), line_length());
          nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_MB_HDR: begin
        if (ch == CHR_MINUS) begin
          nxt = ST_MB_NIL;
        end else if (is_digit(ch)) begin
          elems_left = count_t'(ch - CHR_ZERO);
          nxt = ST_MB_CNT;
        end else begin
          bad = 1'b1;
        end
      end
      ST_MB_NIL_LF: begin
        if (ch == CHR_LF) begin
          await_reply(KIND_NIL_MB, '0, '0, 1'b0, 1'b0);
          nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_MB_CNT: begin
        if (ch == CHR_CR) nxt = ST_MB_CNT_LF;
        else if (is_digit(ch)) elems_left = add_digit(elems_left, ch);
        else bad = 1'b1;
      end
      ST_MB_CNT_LF: begin
        if (ch == CHR_LF) begin
          // count is clipped to the output width
          if (elems_left > count_t'({OUT_BITS{1'b1}})) count_word = {OUT_BITS{1'b1}};
          else count_word = word_t'(elems_left);
          await_reply(KIND_MB_HEADER, '0, count_word, 1'b0, 1'b0);
          nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    // malformed byte: report it, position stays, machine goes dead
    if (bad) begin
      await_reply(KIND_STREAM_ERR, word_t'(stream_pos), '0, 1'b0, 1'b0);
      parser_state = ST_DEAD;
    end else begin
      parser_state = nxt;
      stream_pos   = nxt_pos;
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_tally++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // Compare result transfers, then step the model on input transfers
  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      parser_state  = ST_IDLE;
      stream_pos    = '0;
      payload_start = '0;
      bulk_left     = '0;
      elems_left    = '0;
      awaited_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          fail_tally++;
          $error("unexpected result: kind %0d offset 0x%0h length 0x%0h",
                 out_reply_kind, out_data_offset, out_data_length);
        end else begin
          want = awaited_replies.pop_front();
          check_field("reply_kind", 32'(want.kind), 32'(out_reply_kind));
          check_field("data_offset", want.offset, out_data_offset);
          check_field("data_length", want.length, out_data_length);
          check_field("is_child", 32'(want.child), 32'(out_is_child));
          check_field("last_child", 32'(want.last), 32'(out_last_child));
        end
      end
      if (in_valid && !in_stall) begin
        advance_parser(in_data_byte);
      end
    end
    fail_count  <= fail_tally;
    outstanding <= awaited_replies.size();
  end

endmodule

// ===== bench/tb_resp_reply_stream_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resp_reply_stream_parser_unit: testbench for the reply stream parser
// Feeds a short directed stream covering every reply kind, then random
// well-formed replies with random payload bytes, and closes with one
// malformed byte (or a saturated bulk length) followed by ignored bytes.
// The sender runs in bursts with gaps, the receiver stalls in changing
// patterns. A separate checker predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_resp_reply_stream_parser_unit;
  import rrsp_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_TARGET = 1400;
  localparam int         SETTLE_CYCLES = 16;
  localparam logic [7:0] CHR_ONE       = CHR_ZERO + 8'd1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {
    BREAK_START,
    BREAK_BULK_HDR,
    BREAK_NIL,
    BREAK_BULK_END,
    BREAK_LINE_END,
    BREAK_MB_HDR,
    DEEP_BULK
  } ending_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_reply_kind;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_length;
  logic        out_is_child;
  logic        out_last_child;
  int          fail_count;
  int          outstanding;

  int          cycle_count = 0;
  int          burst_left  = 0;
  int          sent_bytes  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_span  = 0;

  resp_reply_stream_parser_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reply_kind  (out_reply_kind),
    .out_data_offset (out_data_offset),
    .out_data_length (out_data_length),
    .out_is_child    (out_is_child),
    .out_last_child  (out_last_child)
  );

  resp_reply_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reply_kind  (out_reply_kind),
    .out_data_offset (out_data_offset),
    .out_data_length (out_data_length),
    .out_is_child    (out_is_child),
    .out_last_child  (out_last_child),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall: a new pattern for each span of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_span <= 0;
    end else if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(8, 120);
      out_stall  <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
        default:     out_stall <= (stall_span[3:0] < 4'd5);
      endcase
    end
  end

  // One byte transfer; bursts of random length with gaps between
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent_bytes++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_crlf();
    push_byte(CHR_CR);
    push_byte(CHR_LF);
  endtask

  // Decimal count, now and then with leading zeros
  task automatic push_count(input longint unsigned n);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte(CHR_ZERO);
    end
    push_text($sformatf("%0d", n));
  endtask

  function automatic logic [7:0] any_byte_but(input string excluded);
    logic [7:0] b;
    logic       hit;
    do begin
      b   = 8'($urandom_range(0, 255));
      hit = 1'b0;
      for (int i = 0; i < excluded.len(); i++) begin
        if (excluded[i] == b) hit = 1'b1;
      end
    end while (hit);
    return b;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 8);
    if (r < 19) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  // Status, error or integer line; LF inside the body is payload
  task automatic push_line(input logic [7:0] lead);
    push_byte(lead);
    repeat (pick_length()) begin
      push_byte(($urandom_range(0, 5) == 0) ? CHR_LF : any_byte_but("\015"));
    end
    push_crlf();
  endtask

  task automatic push_bulk(input int len);
    push_byte(CHR_DOLLAR);
    push_count(len);
    push_crlf();
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    push_crlf();
  endtask

  task automatic push_nil(input logic [7:0] lead);
    push_byte(lead);
    push_byte(CHR_MINUS);
    push_byte(CHR_ONE);
    push_crlf();
  endtask

  task automatic push_element();
    if ($urandom_range(0, 4) == 0) push_nil(CHR_DOLLAR);
    else push_bulk(pick_length());
  endtask

  task automatic push_multibulk(input int count);
    push_byte(CHR_STAR);
    push_count(count);
    push_crlf();
    repeat (count) push_element();
  endtask

  // Hold the sender until every awaited result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    int              pick;
    logic            paused_once;
    logic            inside_mb;
    longint unsigned huge;
    ending_t         ending;
    paused_once = 1'b0;
    inside_mb   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each reply kind, empty bodies, extreme bytes, children
    push_byte(CHR_PLUS);
    push_crlf();
    push_byte(CHR_MINUS);
    push_byte(8'hFF);
    push_byte(CHR_LF);
    push_byte(8'h00);
    push_crlf();
    push_byte(CHR_COLON);
    push_byte(CHR_ZERO);
    push_crlf();
    push_nil(CHR_DOLLAR);
    push_nil(CHR_STAR);
    push_multibulk(0);
    push_byte(CHR_STAR);
    push_text("2");
    push_crlf();
    push_bulk(0);
    push_nil(CHR_DOLLAR);
    wait_drained();

    // Random well-formed replies
    while (sent_bytes < RANDOM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) push_line(CHR_PLUS);
      else if (pick < 24) push_line(CHR_MINUS);
      else if (pick < 36) push_line(CHR_COLON);
      else if (pick < 56) push_bulk(pick_length());
      else if (pick < 61) push_nil(CHR_DOLLAR);
      else if (pick < 64) push_nil(CHR_STAR);
      else if (pick < 67) push_multibulk(0);
      else if (pick < 93) push_multibulk($urandom_range(1, 6));
      else push_multibulk($urandom_range(7, 15));
      if ((!paused_once && sent_bytes > RANDOM_TARGET / 2) || $urandom_range(0, 59) == 0) begin
        wait_drained();
        paused_once = 1'b1;
      end
    end

    // Closing: at times a saturated multibulk count, then one malformed byte or a saturated bulk length
    case ($urandom_range(0, 2))
      0:       huge = 64'd4294967295;
      1:       huge = 64'd4294967296;
      default: huge = 64'd100000000000 + $urandom;
    endcase
    ending = ending_t'($urandom_range(0, 6));
    if (ending != DEEP_BULK && $urandom_range(0, 1) == 1) begin
      push_byte(CHR_STAR);
      push_count(huge);
      push_crlf();
      repeat ($urandom_range(0, 2)) push_element();
      inside_mb = 1'b1;
    end
    case (ending)
      BREAK_START: begin
        push_byte(inside_mb ? any_byte_but("$") : any_byte_but("$+-*:"));
      end
      BREAK_BULK_HDR: begin
        push_byte(CHR_DOLLAR);
        push_byte(any_byte_but("-0123456789"));
      end
      BREAK_NIL: begin
        push_byte(CHR_DOLLAR);
        push_byte(CHR_MINUS);
        if ($urandom_range(0, 1) == 0) begin
          push_byte(any_byte_but("1"));
        end else begin
          push_byte(CHR_ONE);
          push_byte(any_byte_but("\015"));
        end
      end
      BREAK_BULK_END: begin
        push_byte(CHR_DOLLAR);
        push_text("2");
        push_crlf();
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) begin
          push_byte(any_byte_but("\015"));
        end else begin
          push_byte(CHR_CR);
          push_byte(any_byte_but("\012"));
        end
      end
      BREAK_LINE_END: begin
        push_byte(CHR_PLUS);
        push_text("ok");
        push_byte(CHR_CR);
        push_byte(any_byte_but("\012"));
      end
      BREAK_MB_HDR: begin
        push_byte(CHR_STAR);
        if ($urandom_range(0, 1) == 0) begin
          push_byte(any_byte_but("-0123456789"));
        end else begin
          push_text("12");
          push_byte(any_byte_but("0123456789\015"));
        end
      end
      default: begin
        // saturated bulk length: payload never ends, no result due
        push_byte(CHR_DOLLAR);
        push_count(huge);
        push_crlf();
        repeat (20) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
    // bytes after a stream error are taken and dropped
    repeat ($urandom_range(2, 8)) push_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
